FILE: sv/bhls_pkg.sv
`timescale 1ns / 1ps
// Package for the button hold and LED flash sequencer: command and register
// codes, configuration reset values and shared structs. No dependencies.
package bhls_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0]  HOLD_LIMIT_RST        = CNT_W'(10 * 1000);
  localparam logic [CNT_W-1:0]  FAST_HALF_PERIOD_RST  = CNT_W'(100);
  localparam logic [STEP_W-1:0] FAST_TOGGLE_LIMIT_RST = STEP_W'(10 * 2 * 4);
  localparam logic [CNT_W-1:0]  SLOW_HALF_PERIOD_RST  = CNT_W'(1000);
  localparam logic [CNT_W-1:0]  DUAL_HALF_PERIOD_RST  = CNT_W'(500);
  localparam logic [STEP_W-1:0] DUAL_STEP_LIMIT_RST   = STEP_W'(4 * 5 * 2);
  localparam logic [CNT_W-1:0]  HOLD_ON_TICKS_RST     = CNT_W'(2000);

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE       = 3'd0,
    CMD_FAST_START = 3'd1,
    CMD_SLOW_START = 3'd2,
    CMD_SLOW_STOP  = 3'd3,
    CMD_DUAL_START = 3'd4,
    CMD_HOLD_START = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_LIMIT        = 3'd0,
    REG_FAST_HALF_PERIOD  = 3'd1,
    REG_FAST_TOGGLE_LIMIT = 3'd2,
    REG_SLOW_HALF_PERIOD  = 3'd3,
    REG_DUAL_HALF_PERIOD  = 3'd4,
    REG_DUAL_STEP_LIMIT   = 3'd5,
    REG_HOLD_ON_TICKS     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]  hold_limit;
    logic [CNT_W-1:0]  fast_half_period;
    logic [STEP_W-1:0] fast_toggle_limit;
    logic [CNT_W-1:0]  slow_half_period;
    logic [CNT_W-1:0]  dual_half_period;
    logic [STEP_W-1:0] dual_step_limit;
    logic [CNT_W-1:0]  hold_on_ticks;
  } cfg_t;

  // LED levels and test flag after the current tick
  typedef struct packed {
    logic led_a;
    logic led_b;
    logic test_mode;
  } led_res_t;

endpackage

FILE: sv/bhls_hold_det.sv
`timescale 1ns / 1ps
// Active-low button hold detector: counts ticks while the button is held
// and fires once the count reaches the limit. Depends on bhls_pkg.
module bhls_hold_det (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        level,
  input  logic [bhls_pkg::CNT_W-1:0]  limit,
  output logic                        fire
);
  import bhls_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign fire = !level && (count_r >= limit);

  always_comb begin
    if (level || fire) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: sv/bhls_led_seq.sv
`timescale 1ns / 1ps
// LED mode sequencer: test-mode flag, fast, slow, dual and LED B hold modes
// with their tick and step counters. Depends on bhls_pkg.
module bhls_led_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [bhls_pkg::CMD_W-1:0]  command,
  input  logic                        test_fire,
  input  bhls_pkg::cfg_t              cfg,
  output bhls_pkg::led_res_t          res
);
  import bhls_pkg::*;

  logic              test_flag_r, test_flag_nxt;
  logic              fast_on_r, fast_on_nxt;
  logic [CNT_W-1:0]  fast_ticks_r, fast_ticks_nxt;
  logic [STEP_W-1:0] fast_toggles_r, fast_toggles_nxt;
  logic              slow_on_r, slow_on_nxt;
  logic [CNT_W-1:0]  slow_ticks_r, slow_ticks_nxt;
  logic              dual_on_r, dual_on_nxt;
  logic [CNT_W-1:0]  dual_ticks_r, dual_ticks_nxt;
  logic [STEP_W-1:0] dual_steps_r, dual_steps_nxt;
  logic              bhold_on_r, bhold_on_nxt;
  logic [CNT_W-1:0]  bhold_ticks_r, bhold_ticks_nxt;
  logic              led_a_r, led_a_nxt;
  logic              led_b_r, led_b_nxt;

  always_comb begin
    test_flag_nxt    = test_flag_r;
    fast_on_nxt      = fast_on_r;
    fast_ticks_nxt   = fast_ticks_r;
    fast_toggles_nxt = fast_toggles_r;
    slow_on_nxt      = slow_on_r;
    slow_ticks_nxt   = slow_ticks_r;
    dual_on_nxt      = dual_on_r;
    dual_ticks_nxt   = dual_ticks_r;
    dual_steps_nxt   = dual_steps_r;
    bhold_on_nxt     = bhold_on_r;
    bhold_ticks_nxt  = bhold_ticks_r;
    led_a_nxt        = led_a_r;
    led_b_nxt        = led_b_r;

    // start commands only set the enable; counters keep their values
    unique case (command)
      CMD_FAST_START: fast_on_nxt  = 1'b1;
      CMD_SLOW_START: slow_on_nxt  = 1'b1;
      CMD_SLOW_STOP:  slow_on_nxt  = 1'b0;
      CMD_DUAL_START: dual_on_nxt  = 1'b1;
      CMD_HOLD_START: bhold_on_nxt = 1'b1;
      default: ;
    endcase

    if (test_fire) begin
      test_flag_nxt = !test_flag_r;
      led_a_nxt     = !test_flag_r;
      led_b_nxt     = !test_flag_r;
    end

    if (fast_on_nxt) begin
      slow_on_nxt = 1'b0;
      if (fast_toggles_r >= cfg.fast_toggle_limit) begin
        fast_toggles_nxt = '0;
        fast_on_nxt      = 1'b0;
        fast_ticks_nxt   = '0;
        led_a_nxt        = 1'b0;
      end else if (fast_ticks_r >= cfg.fast_half_period) begin
        fast_ticks_nxt   = '0;
        led_a_nxt        = !led_a_nxt;
        fast_toggles_nxt = fast_toggles_r + STEP_W'(1);
      end else begin
        fast_ticks_nxt = fast_ticks_r + CNT_W'(1);
      end
    end else if (slow_on_nxt) begin
      if (slow_ticks_r >= cfg.slow_half_period) begin
        slow_ticks_nxt = '0;
        led_a_nxt      = !led_a_nxt;
      end else begin
        slow_ticks_nxt = slow_ticks_r + CNT_W'(1);
      end
    end else if (dual_on_nxt) begin
      if (dual_steps_r >= cfg.dual_step_limit) begin
        dual_steps_nxt = '0;
        dual_on_nxt    = 1'b0;
        dual_ticks_nxt = '0;
        led_a_nxt      = 1'b0;
        led_b_nxt      = 1'b0;
      end else if (dual_ticks_r >= cfg.dual_half_period) begin
        dual_ticks_nxt = '0;
        // first step lights LED B alone, later steps swap both
        if (dual_steps_r == '0) begin
          led_a_nxt = 1'b0;
          led_b_nxt = 1'b1;
        end else begin
          led_a_nxt = !led_a_nxt;
          led_b_nxt = !led_b_nxt;
        end
        dual_steps_nxt = dual_steps_r + STEP_W'(1);
      end else begin
        dual_ticks_nxt = dual_ticks_r + CNT_W'(1);
      end
    end else if (bhold_on_nxt) begin
      if (bhold_ticks_r >= cfg.hold_on_ticks) begin
        bhold_ticks_nxt = '0;
        bhold_on_nxt    = 1'b0;
        led_b_nxt       = 1'b0;
      end else begin
        bhold_ticks_nxt = bhold_ticks_r + CNT_W'(1);
        led_b_nxt       = 1'b1;
      end
    end
  end

  assign res.led_a     = led_a_nxt;
  assign res.led_b     = led_b_nxt;
  assign res.test_mode = test_flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_flag_r    <= 1'b0;
      fast_on_r      <= 1'b0;
      fast_ticks_r   <= '0;
      fast_toggles_r <= '0;
      slow_on_r      <= 1'b0;
      slow_ticks_r   <= '0;
      dual_on_r      <= 1'b0;
      dual_ticks_r   <= '0;
      dual_steps_r   <= '0;
      bhold_on_r     <= 1'b0;
      bhold_ticks_r  <= '0;
      led_a_r        <= 1'b0;
      led_b_r        <= 1'b0;
    end else if (step) begin
      test_flag_r    <= test_flag_nxt;
      fast_on_r      <= fast_on_nxt;
      fast_ticks_r   <= fast_ticks_nxt;
      fast_toggles_r <= fast_toggles_nxt;
      slow_on_r      <= slow_on_nxt;
      slow_ticks_r   <= slow_ticks_nxt;
      dual_on_r      <= dual_on_nxt;
      dual_ticks_r   <= dual_ticks_nxt;
      dual_steps_r   <= dual_steps_nxt;
      bhold_on_r     <= bhold_on_nxt;
      bhold_ticks_r  <= bhold_ticks_nxt;
      led_a_r        <= led_a_nxt;
      led_b_r        <= led_b_nxt;
    end
  end

  // fast flash always shuts slow flash off
  a_fast_kills_slow: assert property (@(posedge clk) disable iff (!rst_n)
    (step && fast_on_r) |=> !slow_on_r)
    else $error("slow flash still on after a fast flash tick");

endmodule

FILE: sv/button_hold_and_led_flash_sequencer.sv
`timescale 1ns / 1ps
// An accepted result is registered in the head, or in the skid if the head stalls.
// Throughput: one request per cycle while in_tready is high (skid entry empty).
// A two-entry output buffer keeps in_tready high while one result is stalled.
// Reset (rst_n low, synchronous) clears all counters, flags, LEDs and the
// output buffer, and loads the configuration registers with their defaults.
module button_hold_and_led_flash_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [0] net_button_level, [1] test_button_level, [4:2] command, [7:5] zero
  input  logic [bhls_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] led_a, [1] led_b, [2] network_start, [3] test_mode, [7:4] zero
  output logic [bhls_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bhls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bhls_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import bhls_pkg::*;

  cfg_t     cfg_r;
  logic     step;
  logic     net_fire;
  logic     test_fire;
  led_res_t res;
  logic [OUT_TDATA_W-1:0] res_data;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;
  logic                   pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_limit        <= HOLD_LIMIT_RST;
      cfg_r.fast_half_period  <= FAST_HALF_PERIOD_RST;
      cfg_r.fast_toggle_limit <= FAST_TOGGLE_LIMIT_RST;
      cfg_r.slow_half_period  <= SLOW_HALF_PERIOD_RST;
      cfg_r.dual_half_period  <= DUAL_HALF_PERIOD_RST;
      cfg_r.dual_step_limit   <= DUAL_STEP_LIMIT_RST;
      cfg_r.hold_on_ticks     <= HOLD_ON_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_LIMIT:        cfg_r.hold_limit        <= cfg_data;
        REG_FAST_HALF_PERIOD:  cfg_r.fast_half_period  <= cfg_data;
        REG_FAST_TOGGLE_LIMIT: cfg_r.fast_toggle_limit <= cfg_data[STEP_W-1:0];
        REG_SLOW_HALF_PERIOD:  cfg_r.slow_half_period  <= cfg_data;
        REG_DUAL_HALF_PERIOD:  cfg_r.dual_half_period  <= cfg_data;
        REG_DUAL_STEP_LIMIT:   cfg_r.dual_step_limit   <= cfg_data[STEP_W-1:0];
        REG_HOLD_ON_TICKS:     cfg_r.hold_on_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign step      = in_tvalid && in_tready;

  bhls_hold_det u_net_hold (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (in_tdata[0]),
    .limit (cfg_r.hold_limit),
    .fire  (net_fire)
  );

  bhls_hold_det u_test_hold (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (in_tdata[1]),
    .limit (cfg_r.hold_limit),
    .fire  (test_fire)
  );

  bhls_led_seq u_led_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .command   (in_tdata[4:2]),
    .test_fire (test_fire),
    .cfg       (cfg_r),
    .res       (res)
  );

  assign res_data = {4'b0000, res.test_mode, net_fire, res.led_b, res.led_a};

  // two-entry output buffer: head register plus skid register
  assign pop = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = step;
        out_data_nxt  = res_data;
      end
    end else if (step) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready && step))
    else $error("skid entry filled without a stalled head");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !out_valid_r) |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule
